// ===== rtl/core/uer_pkg.sv =====
// Shared types, codes and constants for the ultrasonic echo ranging unit.
package uer_pkg;

    // Event kinds carried with each input transfer.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_RISE    = 2'd1;
    localparam logic [1:0] ACT_FALL    = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PING_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MAX_MISSES    = 2'd1;
    localparam logic [1:0] CFG_SOUND_SPEED   = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] RST_PING_INTERVAL = 8'd2;
    localparam logic [7:0] RST_MAX_MISSES    = 8'd5;
    localparam logic [8:0] RST_SOUND_SPEED   = 9'd343;

    // Field widths.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SPEED_W = 9;
    localparam int unsigned PROD_W  = TIME_W + SPEED_W;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned QIN_W   = 23;
    localparam int unsigned RECIP_W = 24;
    localparam int unsigned RECIP_SHIFT = 30;

    // A product at or above 65536 * 2000 gives a distance that saturates.
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(64'd131072000);

    // Below the saturation limit, product / 2000 = (product >> 4) / 125, and
    // x / 125 = (x * ceil(2^30 / 125)) >> 30 holds exactly for x < 2^23.
    localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(32'd8589935);

    // Per-event result of the control stage, handed to the distance stage.
    typedef struct packed {
        logic              fire;
        logic              missed;
        logic              measure;
        logic              force_zero;
        logic              sat;
        logic [QIN_W-1:0]  quot_in;
    } t_ctrl_res;

endpackage

// ===== rtl/core/ultrasonic_echo_ranging_unit.sv =====
// Top level of the ultrasonic echo ranging unit: handshakes, config, pipeline.
// Each input transfer is one event (tick, echo rise, echo fall or quiet
// timeout with a microsecond timestamp) and gives exactly one output transfer
// carrying the trigger request, the current distance in mm and the update and
// miss flags. The unit takes one event per clock while the output is not held
// back by the sink. An event passes an input register, a control stage that
// updates the arming state and forms elapsed time times speed of sound, and a
// distance stage that divides by 2000 with a reciprocal multiply and drives
// the output register. Every stage has its own valid bit, so an empty stage
// fills even while a result waits to be taken. Configuration is written
// through a separate channel that is always ready; write it only while no
// event is in flight.
module ultrasonic_echo_ranging_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Event input
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [31:0]                    i_s_tdata,   // [31:0] time_us
    input  logic [1:0]                     i_s_tuser,   // [1:0] action
    // Result output
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [15:0]                    o_m_tdata,   // [15:0] dist_mm
    output logic [2:0]                     o_m_tuser,   // [0] trigger_fire,
                                                        // [1] distance_updated,
                                                        // [2] missed
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [8:0]                     i_cfg_data
);
    import uer_pkg::*;

    // Configuration registers.
    logic [7:0]         r_ping_interval;
    logic [7:0]         r_max_misses;
    logic [SPEED_W-1:0] r_sound_speed;

    // Pipeline registers.
    logic               r_v1;
    logic [1:0]         r_action;
    logic [TIME_W-1:0]  r_time_us;
    logic               r_v2;
    t_ctrl_res          r_res;
    logic               r_v3;
    logic [DIST_W-1:0]  r_out_dist;
    logic [2:0]         r_out_flags;

    logic               out_free, s2_free, s1_free, adv1, adv2;
    t_ctrl_res          ctrl_res;
    logic [DIST_W-1:0]  dist_next;

    // Stage advance: a stage moves when the one after it is empty or moving.
    assign out_free   = !r_v3 || i_m_tready;
    assign adv2       = r_v2 && out_free;
    assign s2_free    = !r_v2 || out_free;
    assign adv1       = r_v1 && s2_free;
    assign s1_free    = !r_v1 || s2_free;
    assign o_s_tready = s1_free;
    assign o_cfg_ready = 1'b1;

    // Configuration write decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_interval <= RST_PING_INTERVAL;
            r_max_misses    <= RST_MAX_MISSES;
            r_sound_speed   <= RST_SOUND_SPEED;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PING_INTERVAL: r_ping_interval <= i_cfg_data[7:0];
                CFG_MAX_MISSES:    r_max_misses    <= i_cfg_data[7:0];
                CFG_SOUND_SPEED:   r_sound_speed   <= i_cfg_data;
                default:           r_sound_speed   <= r_sound_speed;
            endcase
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_s_tvalid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_free) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s1_free && i_s_tvalid) begin
            r_action  <= i_s_tuser;
            r_time_us <= i_s_tdata;
        end
        if (adv1) begin
            r_res <= ctrl_res;
        end
        if (adv2) begin
            r_out_dist  <= dist_next;
            r_out_flags <= {r_res.missed, r_res.measure || r_res.force_zero,
                            r_res.fire};
        end
    end

    uer_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv1),
        .i_action        (r_action),
        .i_time_us       (r_time_us),
        .i_ping_interval (r_ping_interval),
        .i_max_misses    (r_max_misses),
        .i_sound_speed   (r_sound_speed),
        .o_res           (ctrl_res)
    );

    uer_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv2),
        .i_res      (r_res),
        .o_distance (dist_next)
    );

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_out_dist;
    assign o_m_tuser  = r_out_flags;

    // A result held back by the sink keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_m_tready) |=> (r_v3 && $stable(r_out_dist) && $stable(r_out_flags)))
        else $error("stalled result changed");

    // An accepted event always lands in the input register.
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v1)
        else $error("accepted event lost");

endmodule

// ===== rtl/core/uer_ctrl.sv =====
// Event decoder and measurement state: tick phase, arming, start time, misses.
module uer_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [1:0]                    i_action,
    input  logic [uer_pkg::TIME_W-1:0]    i_time_us,
    input  logic [7:0]                    i_ping_interval,
    input  logic [7:0]                    i_max_misses,
    input  logic [uer_pkg::SPEED_W-1:0]   i_sound_speed,
    output uer_pkg::t_ctrl_res            o_res
);
    import uer_pkg::*;

    logic [7:0]        r_tick_phase, n_tick_phase;
    logic              r_armed, n_armed;
    logic              r_start_valid, n_start_valid;
    logic [TIME_W-1:0] r_start_time, n_start_time;
    logic [7:0]        r_miss_count, n_miss_count;

    logic [7:0]        limit;
    logic [8:0]        phase_inc;
    logic              wrap;
    logic [7:0]        miss_inc;
    logic [TIME_W-1:0] elapsed;
    logic [PROD_W-1:0] prod;

    // Tick phase compare; an interval of zero behaves as one.
    assign limit     = (i_ping_interval == 8'd0) ? 8'd1 : i_ping_interval;
    assign phase_inc = {1'b0, r_tick_phase} + 9'd1;
    assign wrap      = phase_inc >= {1'b0, limit};
    assign miss_inc  = (r_miss_count == 8'hFF) ? r_miss_count : r_miss_count + 8'd1;

    // Echo width times speed of sound; the subtraction wraps modulo 2^32.
    assign elapsed = i_time_us - r_start_time;
    assign prod    = PROD_W'(elapsed) * PROD_W'(i_sound_speed);

    // Next state and per-event flags.
    always_comb begin
        n_tick_phase     = r_tick_phase;
        n_armed          = r_armed;
        n_start_valid    = r_start_valid;
        n_start_time     = r_start_time;
        n_miss_count     = r_miss_count;
        o_res.fire       = 1'b0;
        o_res.missed     = 1'b0;
        o_res.measure    = 1'b0;
        o_res.force_zero = 1'b0;
        o_res.sat        = prod >= SAT_LIMIT;
        o_res.quot_in    = prod[QIN_W+3:4];
        unique case (i_action)
            ACT_TICK: begin
                if (wrap) begin
                    n_tick_phase  = 8'd0;
                    n_start_valid = 1'b0;
                    n_armed       = 1'b1;
                    o_res.fire    = 1'b1;
                end else begin
                    n_tick_phase = phase_inc[7:0];
                end
            end
            ACT_RISE: begin
                if (r_armed) begin
                    n_start_time  = i_time_us;
                    n_start_valid = 1'b1;
                end
            end
            ACT_FALL: begin
                if (r_armed && r_start_valid) begin
                    o_res.measure = 1'b1;
                    n_start_valid = 1'b0;
                    n_armed       = 1'b0;
                    n_miss_count  = 8'd0;
                end
            end
            ACT_TIMEOUT: begin
                if (r_armed) begin
                    n_start_valid    = 1'b0;
                    n_armed          = 1'b0;
                    n_miss_count     = miss_inc;
                    o_res.missed     = 1'b1;
                    o_res.force_zero = miss_inc > i_max_misses;
                end
            end
            default: begin
                n_tick_phase = r_tick_phase;
            end
        endcase
    end

    // State advances once per event leaving the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_phase  <= 8'd0;
            r_armed       <= 1'b0;
            r_start_valid <= 1'b0;
            r_start_time  <= '0;
            r_miss_count  <= 8'd0;
        end else if (i_adv) begin
            r_tick_phase  <= n_tick_phase;
            r_armed       <= n_armed;
            r_start_valid <= n_start_valid;
            r_start_time  <= n_start_time;
            r_miss_count  <= n_miss_count;
        end
    end

    // A recorded start only exists inside an armed measurement.
    a_start_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start_valid |-> r_armed)
        else $error("start recorded while not armed");

    // A firing tick leaves the measurement armed with no start recorded.
    a_fire_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.fire) |=> (r_armed && !r_start_valid))
        else $error("trigger did not arm the measurement");

endmodule

// ===== rtl/core/uer_dist.sv =====
// Distance stage: divide by 2000 via a reciprocal, saturate, zero on misses, hold distance.
module uer_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  uer_pkg::t_ctrl_res          i_res,
    output logic [uer_pkg::DIST_W-1:0]  o_distance
);
    import uer_pkg::*;

    localparam int unsigned QP_W = QIN_W + RECIP_W;

    logic [DIST_W-1:0] r_distance;
    logic [QP_W-1:0]   qprod;
    logic [DIST_W-1:0] quot;

    // Quotient by 125 of the product already divided by 16.
    assign qprod = QP_W'(i_res.quot_in) * QP_W'(RECIP_125);
    assign quot  = qprod[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];

    // Distance after this event.
    always_comb begin
        if (i_res.measure) begin
            o_distance = i_res.sat ? {DIST_W{1'b1}} : quot;
        end else if (i_res.force_zero) begin
            o_distance = '0;
        end else begin
            o_distance = r_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance <= '0;
        end else if (i_adv) begin
            r_distance <= o_distance;
        end
    end

    // A saturated measurement stores full scale.
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_res.measure && i_res.sat) |=> (r_distance == {DIST_W{1'b1}}))
        else $error("saturated measurement not at full scale");

endmodule
